// ===== design/char_lcd_command_engine_assert.svh =====
// ----------------------------------------------------------------------------
// char_lcd_command_engine_assert.svh
// Assertion macros used by the checker file of the character LCD engine.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_COMMAND_ENGINE_ASSERT_SVH
`define CHAR_LCD_COMMAND_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while reset is low
`define CLCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while reset is low
`define CLCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/clce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clce_pkg
// Shared codes, handshake structs and address arithmetic of the LCD engine.
// ----------------------------------------------------------------------------
package clce_pkg;

	// item kinds on the input tuser
	localparam logic [1:0] FUNC_CMD   = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;

	// RAM sizes, fixed by the address arithmetic below
	localparam int TEXT_DEPTH  = 80;
	localparam int GLYPH_DEPTH = 64;

	localparam logic [7:0] CHAR_SPACE  = 8'd32;
	localparam logic [7:0] ADDR_LAST   = 8'd79;
	localparam logic [7:0] LINE1_LAST  = 8'd79;
	localparam logic [7:0] LINE2_LAST  = 8'd39;
	localparam logic [6:0] ADDR_HIGH63 = 7'd63;
	localparam logic [6:0] ADDR_FOLD   = 7'd24;
	localparam logic [6:0] HALF_BASE   = 7'd40;

	localparam int IN_W  = 24;
	localparam int OUT_W = 48;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic text_rd;
		logic glyph_rd;
		logic out_load;
	} clce_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_fetch;
	} clce_status_t;

	function automatic logic [6:0] step_addr(logic [6:0] a, logic down);
		logic [7:0] n;
		if (down) begin
			n = (a == 7'd0) ? ADDR_LAST : {1'b0, a} - 8'd1;
		end else begin
			n = {1'b0, a} + 8'd1;
		end
		if (n > ADDR_LAST) begin
			n = 8'd0;
		end
		return n[6:0];
	endfunction

	function automatic logic [6:0] step_shift(logic [6:0] s, logic down, logic two_line);
		logic [7:0] last;
		logic [7:0] n;
		last = two_line ? LINE2_LAST : LINE1_LAST;
		if (down) begin
			n = (s == 7'd0) ? last : {1'b0, s} - 8'd1;
		end else begin
			n = {1'b0, s} + 8'd1;
		end
		if (n > last) begin
			n = 8'd0;
		end
		return n[6:0];
	endfunction

	function automatic logic [7:0] sub_if(logic [7:0] x, logic [7:0] k);
		return (x >= k) ? x - k : x;
	endfunction

	// screen row/col through the display shift to a text address
	function automatic logic [6:0] map_pos(logic [1:0] row, logic [4:0] col,
			logic [6:0] shift, logic two_line);
		logic [6:0] row_base;
		logic [6:0] base;
		logic [7:0] x;
		logic [6:0] pos;
		case (row)
			2'd0:    row_base = 7'd0;
			2'd1:    row_base = 7'd40;
			2'd2:    row_base = 7'd20;
			default: row_base = 7'd60;
		endcase
		base = row_base + {2'b00, col};
		if (!two_line) begin
			x = {1'b0, base} + {1'b0, shift};
			x = sub_if(x, 8'd160);
			x = sub_if(x, 8'd80);
			pos = x[6:0];
		end else if (base < HALF_BASE) begin
			x = {1'b0, base} + {1'b0, shift};
			x = sub_if(x, 8'd160);
			x = sub_if(x, 8'd80);
			x = sub_if(x, 8'd40);
			pos = x[6:0];
		end else begin
			x = {1'b0, base - HALF_BASE} + {1'b0, shift};
			x = sub_if(x, 8'd160);
			x = sub_if(x, 8'd80);
			x = sub_if(x, 8'd40);
			pos = x[6:0] + HALF_BASE;
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

// ===== design/clce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== design/clce_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clce_ctrl
// Sequencer: accept, execute, text read, glyph read, result hand-off.
// ----------------------------------------------------------------------------
module clce_ctrl
	import clce_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire clce_status_t status,
	output clce_cmd_t         cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_TRD  = 3'd2;
	localparam logic [2:0] ST_GRD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.is_fetch ? ST_TRD : ST_DONE;
			end
			ST_TRD: begin
				cmd.text_rd = 1'b1;
				state_d     = ST_GRD;
			end
			ST_GRD: begin
				cmd.glyph_rd = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// output register free, or emptied this cycle
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
endmodule
`default_nettype wire

// ===== design/clce_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clce_dp
// Datapath: command decode, status registers, text and glyph RAMs, fetch.
// ----------------------------------------------------------------------------
module clce_dp
	import clce_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       func,
	input  wire logic [7:0]       value,
	input  wire logic [1:0]       row,
	input  wire logic [4:0]       col,
	input  wire logic [2:0]       glyph_line,
	input  wire clce_cmd_t        cmd,
	output clce_status_t          status,
	output logic      [OUT_W-1:0] out_data
);
	localparam int TAW = $clog2(TEXT_DEPTH);
	localparam int GAW = $clog2(GLYPH_DEPTH);

	// captured item
	logic [1:0] func_q;
	logic [7:0] value_q;
	logic [1:0] row_q;
	logic [4:0] col_q;
	logic [2:0] gline_q;

	// controller state
	logic [6:0] addr_count_q;
	logic [5:0] glyph_addr_q;
	logic       sel_text_q;
	logic       step_down_q;
	logic       auto_shift_q;
	logic [6:0] shift_q;
	logic       two_line_q;
	logic [2:0] disp_q;

	// per-entry valid, cleared by reset; the text bits also by the clear command
	logic [TEXT_DEPTH-1:0]  tvld_q;
	logic [GLYPH_DEPTH-1:0] gvld_q;

	// fetch path
	logic [6:0] pos_q;
	logic       cur_q;
	logic       tval_q;
	logic [7:0] code_q;
	logic       cust_q;
	logic       gval_q;
	logic [OUT_W-1:0] out_q;

	logic           t_we;
	logic [TAW-1:0] t_waddr;
	logic [7:0]     t_rdata;
	logic           g_we;
	logic [GAW-1:0] g_waddr;
	logic [GAW-1:0] g_raddr;
	logic [7:0]     g_rdata;
	logic [7:0]     code_d;
	logic [6:0]     set_addr;
	logic [7:0]     cline;
	logic           in_range;

	assign status.is_fetch = (func_q == FUNC_FETCH);

	assign in_range = (addr_count_q < TEXT_DEPTH);
	assign t_we     = cmd.exec && (func_q == FUNC_DATA) && sel_text_q && in_range;
	assign t_waddr  = addr_count_q[TAW-1:0];
	assign g_we     = cmd.exec && (func_q == FUNC_DATA) && !sel_text_q;
	assign g_waddr  = glyph_addr_q[GAW-1:0];

	assign code_d  = tval_q ? t_rdata : CHAR_SPACE;
	assign g_raddr = GAW'({code_d[2:0], gline_q});
	assign cline   = (cust_q && gval_q) ? g_rdata : 8'd0;

	// set-address command: fold 64..127 down in two-line mode
	assign set_addr = (two_line_q && value_q[6:0] > ADDR_HIGH63) ?
		value_q[6:0] - ADDR_FOLD : value_q[6:0];

	clce_ram #(
		.WIDTH(8),
		.DEPTH(TEXT_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(value_q),
		.re   (cmd.text_rd),
		.raddr(pos_q[TAW-1:0]),
		.rdata(t_rdata)
	);

	clce_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (g_we),
		.waddr(g_waddr),
		.wdata(value_q),
		.re   (cmd.glyph_rd),
		.raddr(g_raddr),
		.rdata(g_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= value;
			row_q   <= row;
			col_q   <= col;
			gline_q <= glyph_line;
		end
		if (cmd.exec) begin
			pos_q <= map_pos(row_q, col_q, shift_q, two_line_q);
		end
		if (cmd.text_rd) begin
			tval_q <= tvld_q[pos_q[TAW-1:0]];
			cur_q  <= (pos_q == addr_count_q);
		end
		if (cmd.glyph_rd) begin
			code_q <= code_d;
			cust_q <= (code_d < 8'd8);
			gval_q <= gvld_q[g_raddr];
		end
		if (cmd.out_load) begin
			if (status.is_fetch) begin
				out_q <= {6'd0, sel_text_q, glyph_addr_q, shift_q, addr_count_q,
					disp_q[0], disp_q[1], disp_q[2], cline, cust_q, cur_q, code_q};
			end else begin
				out_q <= {6'd0, sel_text_q, glyph_addr_q, shift_q, addr_count_q,
					disp_q[0], disp_q[1], disp_q[2], 18'd0};
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q       <= FUNC_CMD;
			addr_count_q <= '0;
			glyph_addr_q <= '0;
			sel_text_q   <= 1'b1;
			step_down_q  <= 1'b0;
			auto_shift_q <= 1'b0;
			shift_q      <= '0;
			two_line_q   <= 1'b0;
			disp_q       <= '0;
			tvld_q       <= '0;
			gvld_q       <= '0;
		end else begin
			if (cmd.capture) begin
				func_q <= func;
			end
			if (cmd.exec && func_q == FUNC_CMD) begin
				unique casez (value_q)
					8'b1???????: begin
						addr_count_q <= set_addr;
						sel_text_q   <= 1'b1;
					end
					8'b01??????: begin
						glyph_addr_q <= value_q[5:0];
						sel_text_q   <= 1'b0;
					end
					8'b001?????: begin
						two_line_q <= value_q[3];
					end
					8'b0001????: begin
						if (value_q[3]) begin
							shift_q <= step_shift(shift_q, value_q[2], two_line_q);
						end else begin
							addr_count_q <= step_addr(addr_count_q, value_q[2]);
						end
					end
					8'b00001???: begin
						disp_q <= value_q[2:0];
					end
					8'b000001??: begin
						step_down_q  <= ~value_q[1];
						auto_shift_q <= value_q[0];
					end
					8'b0000001?: begin
						addr_count_q <= '0;
						shift_q      <= '0;
					end
					8'b00000001: begin
						tvld_q       <= '0;
						addr_count_q <= '0;
						shift_q      <= '0;
					end
					8'b00000000: begin
					end
				endcase
			end
			if (cmd.exec && func_q == FUNC_DATA) begin
				if (sel_text_q) begin
					if (in_range) begin
						tvld_q[t_waddr] <= 1'b1;
					end
					addr_count_q <= step_addr(addr_count_q, step_down_q);
					if (auto_shift_q) begin
						shift_q <= step_shift(shift_q, step_down_q, two_line_q);
					end
				end else begin
					gvld_q[g_waddr] <= 1'b1;
					glyph_addr_q    <= glyph_addr_q + 6'd1;
				end
			end
		end
	end

	assign out_data = out_q;
endmodule
`default_nettype wire

// ===== design/char_lcd_command_engine.sv =====
// A fetch passes through execute, text RAM read, glyph RAM read and the output
// register; a command or data write through execute, then the output register.
// The engine holds one item at a time; the text RAM read followed by the
// dependent glyph RAM read makes a fetch take longer than a write.
// Reset (arst_n low): text reads as spaces, glyph RAM as zero, status cleared,
// no beat pending; no clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_command_engine
// Character LCD controller core: commands, DDRAM/CGRAM writes, display fetch.
// ----------------------------------------------------------------------------
// Input beat: tuser carries the kind (command, data, fetch); tdata carries the
// byte and the fetch coordinates. Every input beat yields one output beat with
// the fetched character (zero on writes) and the status after the item.
// The controller accepts a new beat while the previous result still waits on
// m_tready; the output register holds it until taken.
// Text entries and glyph entries carry valid bits so reset clears both, and the
// clear command clears the text, without a clearing pass over the RAMs.
// ----------------------------------------------------------------------------
module char_lcd_command_engine
	import clce_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// value[7:0], row[9:8], col[14:10], glyph_line[17:15], zero[23:18]
	input  wire logic [IN_W-1:0]  s_tdata,
	// func[1:0]
	input  wire logic [1:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// char_code[7:0], at_cursor[8], is_custom[9], custom_line[17:10],
	// display_on[18], cursor_on[19], cursor_blink[20], address_counter[27:21],
	// shift_amount[34:28], glyph_address[40:35], text_ram_selected[41],
	// zero[47:42]
	output logic      [OUT_W-1:0] m_tdata
);
	clce_cmd_t    cmd;
	clce_status_t status;

	// sequencer: one item at a time
	clce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// decode, state, RAMs, fetch mapping and output register
	clce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (s_tuser),
		.value     (s_tdata[7:0]),
		.row       (s_tdata[9:8]),
		.col       (s_tdata[14:10]),
		.glyph_line(s_tdata[17:15]),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata)
	);
endmodule
`default_nettype wire

// ===== design/clce_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clce_checker
// Port-level checks of the LCD engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_command_engine_assert.svh"

module clce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata
);
	// a stalled result beat stays put
	`CLCE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	// one item in flight: no second accept right after one
	`CLCE_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input ready right after an accept")
	// glyph line only comes with a custom code
	`CLCE_ASSERT_NOW(a_cline, m_tvalid && !m_tdata[9], m_tdata[17:10] == 8'd0, "custom line without custom code")
	// custom flag means a code below 8
	`CLCE_ASSERT_NOW(a_custom, m_tvalid && m_tdata[9], m_tdata[7:3] == 5'd0, "custom flag on a code of 8 or more")
	// display shift stays at or below 79, and the pad bits stay zero
	`CLCE_ASSERT_NOW(a_shift, m_tvalid, m_tdata[34:28] <= 7'd79 && m_tdata[47:42] == 6'd0, "shift out of range or pad bits set")
endmodule

bind char_lcd_command_engine clce_checker u_clce_checker (.*);
`default_nettype wire
